### rtl/owtr_pkg.sv
// ----------------------------------------------------------------------------
// owtr_pkg
// Shared types and constants of the one-wire temperature reader.
// ----------------------------------------------------------------------------
`default_nettype none

package owtr_pkg;

  // Sequence phases
  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_R1_LOW   = 5'd1,
    PH_R1_WAIT  = 5'd2,
    PH_R1_REC   = 5'd3,
    PH_W1_START = 5'd4,
    PH_W1_BODY  = 5'd5,
    PH_W2_START = 5'd6,
    PH_W2_BODY  = 5'd7,
    PH_CONV     = 5'd8,
    PH_R2_LOW   = 5'd9,
    PH_R2_WAIT  = 5'd10,
    PH_R2_REC   = 5'd11,
    PH_W3_START = 5'd12,
    PH_W3_BODY  = 5'd13,
    PH_W4_START = 5'd14,
    PH_W4_BODY  = 5'd15,
    PH_RL_START = 5'd16,
    PH_RL_SAMP  = 5'd17,
    PH_RL_REC   = 5'd18,
    PH_RH_START = 5'd19,
    PH_RH_SAMP  = 5'd20,
    PH_RH_REC   = 5'd21
  } phase_e;

  // Item kind carried in tuser
  typedef enum logic {
    MODE_TICK  = 1'b0,
    MODE_START = 1'b1
  } mode_e;

  // Register map, by word index
  typedef enum logic [2:0] {
    REG_RESET_LOW   = 3'd0,
    REG_PRES_SAMPLE = 3'd1,
    REG_RESET_REC   = 3'd2,
    REG_SLOT_START  = 3'd3,
    REG_WRITE_SLOT  = 3'd4,
    REG_READ_SAMPLE = 3'd5,
    REG_READ_REC    = 3'd6,
    REG_CONV_WAIT   = 3'd7
  } reg_idx_e;

  // Bus commands
  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;
  localparam logic [7:0] CMD_NONE     = 8'h00;

  // Timing register reset values (microseconds)
  localparam logic [9:0]  RST_RESET_LOW   = 10'd485;
  localparam logic [7:0]  RST_PRES_SAMPLE = 8'd65;
  localparam logic [9:0]  RST_RESET_REC   = 10'd420;
  localparam logic [3:0]  RST_SLOT_START  = 4'd2;
  localparam logic [6:0]  RST_WRITE_SLOT  = 7'd65;
  localparam logic [5:0]  RST_READ_SAMPLE = 6'd13;
  localparam logic [6:0]  RST_READ_REC    = 7'd45;
  localparam logic [19:0] RST_CONV_WAIT   = 20'd750000;

  typedef struct packed {
    logic [9:0]  reset_low_time;
    logic [7:0]  presence_sample_time;
    logic [9:0]  reset_recovery_time;
    logic [3:0]  slot_start_time;
    logic [6:0]  write_slot_time;
    logic [5:0]  read_sample_time;
    logic [6:0]  read_recovery_time;
    logic [19:0] conversion_wait_time;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic signed [7:0] whole_degrees;
    logic [15:0]       raw_temperature;
    logic              present;
    logic              done_res;
    logic              busy_res;
    logic              drive_low;
  } res_t;

endpackage

`default_nettype wire

### rtl/owtr_seq.sv
// ----------------------------------------------------------------------------
// owtr_seq
// Bus sequencer: phase, slot timer, shift byte and result word. Takes one
// item per step and returns the status that follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module owtr_seq
  import owtr_pkg::*;
(
  input  var logic clk_i,
  input  var logic rst_ni,
  input  var logic step_i,
  input  var logic mode_i,
  input  var logic line_level_i,
  input  var cfg_t cfg_i,
  output res_t     res_o
);

  phase_e      phase_q, phase_d;
  logic [19:0] tick_q, tick_d, tick_inc;
  logic [7:0]  shift_q, shift_d;
  logic [2:0]  bit_q, bit_d, bit_inc;
  logic [7:0]  low_q, low_d;
  logic [15:0] result_q, result_d;
  logic        pres_q, pres_d;
  logic        done;
  logic        drive;

  // Next state for one item
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    shift_d  = shift_q;
    bit_d    = bit_q;
    low_d    = low_q;
    result_d = result_q;
    pres_d   = pres_q;
    done     = 1'b0;
    tick_inc = tick_q + 20'd1;
    bit_inc  = bit_q + 3'd1;

    if (mode_i == MODE_START) begin
      if (phase_q == PH_IDLE) begin
        pres_d  = 1'b0;
        phase_d = PH_R1_LOW;
        tick_d  = '0;
      end
    end else if (phase_q != PH_IDLE) begin
      tick_d = tick_inc;
      case (phase_q)
        PH_R1_LOW, PH_R2_LOW: begin
          if (tick_inc >= {10'd0, cfg_i.reset_low_time}) begin
            phase_d = phase_e'(phase_q + 5'd1);
            tick_d  = '0;
          end
        end
        PH_R1_WAIT, PH_R2_WAIT: begin
          if (tick_inc >= {12'd0, cfg_i.presence_sample_time}) begin
            if (phase_q == PH_R1_WAIT) pres_d = ~line_level_i;
            phase_d = phase_e'(phase_q + 5'd1);
            tick_d  = '0;
          end
        end
        PH_R1_REC: begin
          if (tick_inc >= {10'd0, cfg_i.reset_recovery_time}) begin
            tick_d = '0;
            if (!pres_q) begin
              // nobody answered: end with a zero result
              result_d = '0;
              phase_d  = PH_IDLE;
              done     = 1'b1;
            end else begin
              phase_d = PH_W1_START;
              shift_d = CMD_SKIP_ROM;
              bit_d   = '0;
            end
          end
        end
        PH_R2_REC: begin
          if (tick_inc >= {10'd0, cfg_i.reset_recovery_time}) begin
            tick_d  = '0;
            phase_d = PH_W3_START;
            shift_d = CMD_SKIP_ROM;
            bit_d   = '0;
          end
        end
        PH_W1_START, PH_W2_START, PH_W3_START, PH_W4_START,
        PH_RL_START, PH_RH_START: begin
          if (tick_inc >= {16'd0, cfg_i.slot_start_time}) begin
            phase_d = phase_e'(phase_q + 5'd1);
            tick_d  = '0;
          end
        end
        PH_W1_BODY, PH_W2_BODY, PH_W3_BODY, PH_W4_BODY: begin
          if (tick_inc >= {13'd0, cfg_i.write_slot_time}) begin
            tick_d  = '0;
            shift_d = {1'b0, shift_q[7:1]};
            bit_d   = bit_inc;
            if (bit_inc != 3'd0) begin
              phase_d = phase_e'(phase_q - 5'd1);
            end else begin
              // byte sent: move to the next command or step
              case (phase_q)
                PH_W1_BODY: begin
                  phase_d = PH_W2_START;
                  shift_d = CMD_CONVERT;
                end
                PH_W2_BODY: phase_d = PH_CONV;
                PH_W3_BODY: begin
                  phase_d = PH_W4_START;
                  shift_d = CMD_READ_PAD;
                end
                default: begin
                  phase_d = PH_RL_START;
                  shift_d = CMD_NONE;
                end
              endcase
            end
          end
        end
        PH_CONV: begin
          if (tick_inc >= cfg_i.conversion_wait_time) begin
            phase_d = PH_R2_LOW;
            tick_d  = '0;
          end
        end
        PH_RL_SAMP, PH_RH_SAMP: begin
          if (tick_inc >= {14'd0, cfg_i.read_sample_time}) begin
            shift_d = {line_level_i, shift_q[7:1]};
            phase_d = phase_e'(phase_q + 5'd1);
            tick_d  = '0;
          end
        end
        PH_RL_REC, PH_RH_REC: begin
          if (tick_inc >= {13'd0, cfg_i.read_recovery_time}) begin
            tick_d = '0;
            bit_d  = bit_inc;
            if (bit_inc != 3'd0) begin
              phase_d = phase_e'(phase_q - 5'd2);
            end else if (phase_q == PH_RL_REC) begin
              low_d   = shift_q;
              phase_d = PH_RH_START;
              shift_d = CMD_NONE;
            end else begin
              result_d = {shift_q, low_q};
              phase_d  = PH_IDLE;
              done     = 1'b1;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
          tick_d  = '0;
        end
      endcase
    end
  end

  // Bus drive for the state after the item
  always_comb begin
    case (phase_d)
      PH_R1_LOW, PH_R2_LOW, PH_W1_START, PH_W2_START, PH_W3_START,
      PH_W4_START, PH_RL_START, PH_RH_START: drive = 1'b1;
      PH_W1_BODY, PH_W2_BODY, PH_W3_BODY, PH_W4_BODY: drive = ~shift_d[0];
      default: drive = 1'b0;
    endcase
  end

  assign res_o.drive_low       = drive;
  assign res_o.busy_res        = (phase_d != PH_IDLE);
  assign res_o.done_res        = done;
  assign res_o.present         = pres_d;
  assign res_o.raw_temperature = result_d;
  assign res_o.whole_degrees   = result_d[11:4];

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tick_q   <= '0;
      shift_q  <= '0;
      bit_q    <= '0;
      low_q    <= '0;
      result_q <= '0;
      pres_q   <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      shift_q  <= shift_d;
      bit_q    <= bit_d;
      low_q    <= low_d;
      result_q <= result_d;
      pres_q   <= pres_d;
    end
  end

endmodule

`default_nettype wire

### rtl/onewire_temperature_reader.sv
// ----------------------------------------------------------------------------
// onewire_temperature_reader
// One-wire bus master that runs a temperature conversion and reads back the
// raw value, with APB timing registers and stream in/out ports.
// ----------------------------------------------------------------------------
// Each input item is a microsecond tick (tuser = 0) carrying the sampled bus
// level, or a start request (tuser = 1) that is acted on only while idle. Every
// item produces exactly one result item in the cycle after it is accepted: bus
// drive, busy, done, presence and the latest temperature. One item is taken
// per cycle; the only limit is the single output register, which accepts a
// new item whenever it is empty or being drained in the same cycle. The
// timing registers should be written only while the block is idle.
`default_nettype none

module onewire_temperature_reader
  import owtr_pkg::*;
(
  input  var logic        clk_i,
  input  var logic        rst_ni,
  // input stream
  input  var logic        s_axis_tvalid,
  output logic            s_axis_tready,
  input  var logic [7:0]  s_axis_tdata,   // [0] line_level, [7:1] zero
  input  var logic        s_axis_tuser,   // [0] mode
  // result stream
  output logic            m_axis_tvalid,
  input  var logic        m_axis_tready,
  output logic [31:0]     m_axis_tdata,   // [0] drive_low, [1] busy_res,
                                          // [2] done_res, [3] present,
                                          // [19:4] raw_temperature,
                                          // [27:20] whole_degrees, [31:28] 0
  // configuration
  input  var logic        psel,
  input  var logic        penable,
  input  var logic        pwrite,
  input  var logic [4:0]  paddr,
  input  var logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  cfg_t     cfg_q;
  reg_idx_e reg_sel;
  logic     cfg_wr;
  logic     accept;
  res_t     res;
  logic     out_valid_q;
  res_t     out_q;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time       <= RST_RESET_LOW;
      cfg_q.presence_sample_time <= RST_PRES_SAMPLE;
      cfg_q.reset_recovery_time  <= RST_RESET_REC;
      cfg_q.slot_start_time      <= RST_SLOT_START;
      cfg_q.write_slot_time      <= RST_WRITE_SLOT;
      cfg_q.read_sample_time     <= RST_READ_SAMPLE;
      cfg_q.read_recovery_time   <= RST_READ_REC;
      cfg_q.conversion_wait_time <= RST_CONV_WAIT;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_RESET_LOW:   cfg_q.reset_low_time       <= pwdata[9:0];
        REG_PRES_SAMPLE: cfg_q.presence_sample_time <= pwdata[7:0];
        REG_RESET_REC:   cfg_q.reset_recovery_time  <= pwdata[9:0];
        REG_SLOT_START:  cfg_q.slot_start_time      <= pwdata[3:0];
        REG_WRITE_SLOT:  cfg_q.write_slot_time      <= pwdata[6:0];
        REG_READ_SAMPLE: cfg_q.read_sample_time     <= pwdata[5:0];
        REG_READ_REC:    cfg_q.read_recovery_time   <= pwdata[6:0];
        REG_CONV_WAIT:   cfg_q.conversion_wait_time <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_sel)
      REG_RESET_LOW:   prdata = {22'd0, cfg_q.reset_low_time};
      REG_PRES_SAMPLE: prdata = {24'd0, cfg_q.presence_sample_time};
      REG_RESET_REC:   prdata = {22'd0, cfg_q.reset_recovery_time};
      REG_SLOT_START:  prdata = {28'd0, cfg_q.slot_start_time};
      REG_WRITE_SLOT:  prdata = {25'd0, cfg_q.write_slot_time};
      REG_READ_SAMPLE: prdata = {26'd0, cfg_q.read_sample_time};
      REG_READ_REC:    prdata = {25'd0, cfg_q.read_recovery_time};
      REG_CONV_WAIT:   prdata = {12'd0, cfg_q.conversion_wait_time};
      default:         prdata = '0;
    endcase
  end

  // Input side: free while the output register is empty or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  owtr_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .mode_i       (s_axis_tuser),
    .line_level_i (s_axis_tdata[0]),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q};

`ifndef SYNTHESIS
  // every accepted item leaves a result behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  // a full, stalled output register blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stalled");

  // the finishing item reports idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2]) |-> !m_axis_tdata[1])
    else $error("done reported while busy");

  // the bus is never pulled low while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[1]) |-> !m_axis_tdata[0])
    else $error("bus driven low while idle");
`endif

endmodule

`default_nettype wire

### sim/onewire_temperature_reader_test.sv
// ----------------------------------------------------------------------------
// onewire_temperature_reader_test
// Self-checking bench for the one-wire temperature reader. Short tick/start
// script first, then randomized read sequences under several timing setups,
// each status transfer checked against a cycle-free model of the sequencer.
// ----------------------------------------------------------------------------
module onewire_temperature_reader_test
  import owtr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Clock, reset and DUT ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [0] line_level, [7:1] zero
  logic        s_axis_tuser = 1'b0;  // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [0] drive_low, [1] busy_res, [2] done_res,
                                     // [3] present, [19:4] raw_temperature,
                                     // [27:20] whole_degrees
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  onewire_temperature_reader uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Status words with an obvious value
  localparam res_t QUIET     = '0;
  localparam res_t OPENING   = '{whole_degrees: '0, raw_temperature: '0, present: 1'b0,
                                 done_res: 1'b0, busy_res: 1'b1, drive_low: 1'b1};
  localparam res_t NO_ANSWER = '{whole_degrees: '0, raw_temperature: '0, present: 1'b0,
                                 done_res: 1'b1, busy_res: 1'b0, drive_low: 1'b0};

  // Scratchpad words that hit the sign and range corners of whole_degrees
  localparam logic [15:0] TEMP_CORNERS [6] = '{16'hFFFF, 16'h0000, 16'h07F0,
                                               16'h0800, 16'h8000, 16'h7FFF};

  typedef struct {
    mode_e  kind;
    logic   level;
    bit     typed;
    res_t   want;
  } step_t;

  // Script run with every timing register at zero (each phase lasts one tick)
  step_t script [15] = '{
    '{MODE_TICK,  1'b1, 1'b1, QUIET},      // idle tick right after reset
    '{MODE_TICK,  1'b0, 1'b1, QUIET},      // idle tick, bus low
    '{MODE_START, 1'b0, 1'b1, OPENING},    // start: reset pulse begins
    '{MODE_START, 1'b1, 1'b1, OPENING},    // start while busy is dropped
    '{MODE_TICK,  1'b0, 1'b0, QUIET},      // reset pulse ends on first tick
    '{MODE_TICK,  1'b1, 1'b0, QUIET},      // bus high at sample: no device
    '{MODE_TICK,  1'b0, 1'b1, NO_ANSWER},  // recovery ends, empty result
    '{MODE_TICK,  1'b1, 1'b1, QUIET},      // back to idle
    '{MODE_START, 1'b1, 1'b1, OPENING},
    '{MODE_TICK,  1'b1, 1'b0, QUIET},
    '{MODE_TICK,  1'b0, 1'b0, QUIET},      // device pulls low: present
    '{MODE_TICK,  1'b1, 1'b0, QUIET},      // first skip-ROM slot opens
    '{MODE_TICK,  1'b0, 1'b0, QUIET},
    '{MODE_START, 1'b0, 1'b0, QUIET},      // dropped again, mid write slot
    '{MODE_TICK,  1'b1, 1'b0, QUIET}
  };

  // Model state of the sequencer and its timing registers
  cfg_t        timing;
  phase_e      rd_phase = PH_IDLE;
  logic [19:0] rd_ticks = '0;
  logic [7:0]  rd_shift = '0;
  logic [2:0]  rd_bit = '0;
  logic [7:0]  rd_lsb = '0;
  logic [15:0] rd_word = '0;
  logic        rd_present = 1'b0;

  res_t status_due [$];
  int   mismatches = 0;
  int   burst_left = 10;

  function automatic void go(input phase_e p);
    rd_phase = p;
    rd_ticks = '0;
  endfunction

  function automatic void go_byte(input phase_e p, input logic [7:0] cmd);
    go(p);
    rd_shift = cmd;
    rd_bit = '0;
  endfunction

  // Counts one tick of the current phase; true once the duration is spent
  function automatic bit timer_expired(input logic [19:0] dur);
    rd_ticks = rd_ticks + 20'd1;
    if (rd_ticks >= dur) begin
      rd_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // One microsecond of bus activity; returns 1 when the sequence completes
  function automatic bit advance_bus(input logic lvl);
    case (rd_phase)
      PH_R1_LOW, PH_R2_LOW: begin
        if (timer_expired(timing.reset_low_time)) go(phase_e'(rd_phase + 5'd1));
      end
      PH_R1_WAIT, PH_R2_WAIT: begin
        if (timer_expired(timing.presence_sample_time)) begin
          // only the first reset pulse decides presence
          if (rd_phase == PH_R1_WAIT) rd_present = ~lvl;
          go(phase_e'(rd_phase + 5'd1));
        end
      end
      PH_R1_REC: begin
        if (timer_expired(timing.reset_recovery_time)) begin
          if (!rd_present) begin
            rd_word = '0;
            go(PH_IDLE);
            return 1'b1;
          end
          go_byte(PH_W1_START, CMD_SKIP_ROM);
        end
      end
      PH_R2_REC: begin
        if (timer_expired(timing.reset_recovery_time)) go_byte(PH_W3_START, CMD_SKIP_ROM);
      end
      PH_W1_START, PH_W2_START, PH_W3_START, PH_W4_START, PH_RL_START, PH_RH_START: begin
        if (timer_expired(timing.slot_start_time)) go(phase_e'(rd_phase + 5'd1));
      end
      PH_W1_BODY, PH_W2_BODY, PH_W3_BODY, PH_W4_BODY: begin
        if (timer_expired(timing.write_slot_time)) begin
          rd_shift = rd_shift >> 1;
          rd_bit = rd_bit + 3'd1;
          if (rd_bit != 3'd0) go(phase_e'(rd_phase - 5'd1));
          else begin
            case (rd_phase)
              PH_W1_BODY: go_byte(PH_W2_START, CMD_CONVERT);
              PH_W2_BODY: go(PH_CONV);
              PH_W3_BODY: go_byte(PH_W4_START, CMD_READ_PAD);
              default:    go_byte(PH_RL_START, CMD_NONE);
            endcase
          end
        end
      end
      PH_CONV: begin
        if (timer_expired(timing.conversion_wait_time)) go(PH_R2_LOW);
      end
      PH_RL_SAMP, PH_RH_SAMP: begin
        if (timer_expired(timing.read_sample_time)) begin
          rd_shift = {lvl, rd_shift[7:1]};
          go(phase_e'(rd_phase + 5'd1));
        end
      end
      PH_RL_REC, PH_RH_REC: begin
        if (timer_expired(timing.read_recovery_time)) begin
          rd_bit = rd_bit + 3'd1;
          if (rd_bit != 3'd0) go(phase_e'(rd_phase - 5'd2));
          else if (rd_phase == PH_RL_REC) begin
            rd_lsb = rd_shift;
            go_byte(PH_RH_START, CMD_NONE);
          end else begin
            rd_word = {rd_shift, rd_lsb};
            go(PH_IDLE);
            return 1'b1;
          end
        end
      end
      default: go(PH_IDLE);
    endcase
    return 1'b0;
  endfunction

  // Status word that one accepted item produces
  function automatic void predict_status(input mode_e m, input logic lvl, output res_t r);
    bit fin;
    fin = 1'b0;
    if (m == MODE_START) begin
      if (rd_phase == PH_IDLE) begin
        rd_present = 1'b0;
        go(PH_R1_LOW);
      end
    end else if (rd_phase != PH_IDLE) begin
      fin = advance_bus(lvl);
    end
    case (rd_phase)
      PH_R1_LOW, PH_R2_LOW, PH_W1_START, PH_W2_START, PH_W3_START, PH_W4_START,
      PH_RL_START, PH_RH_START:
        r.drive_low = 1'b1;
      PH_W1_BODY, PH_W2_BODY, PH_W3_BODY, PH_W4_BODY:
        r.drive_low = ~rd_shift[0];
      default:
        r.drive_low = 1'b0;
    endcase
    r.busy_res        = (rd_phase != PH_IDLE);
    r.done_res        = fin;
    r.present         = rd_present;
    r.raw_temperature = rd_word;
    r.whole_degrees   = rd_word[11:4];
  endfunction

  function automatic logic [31:0] reg_value(input cfg_t c, input reg_idx_e idx);
    case (idx)
      REG_RESET_LOW:   return 32'(c.reset_low_time);
      REG_PRES_SAMPLE: return 32'(c.presence_sample_time);
      REG_RESET_REC:   return 32'(c.reset_recovery_time);
      REG_SLOT_START:  return 32'(c.slot_start_time);
      REG_WRITE_SLOT:  return 32'(c.write_slot_time);
      REG_READ_SAMPLE: return 32'(c.read_sample_time);
      REG_READ_REC:    return 32'(c.read_recovery_time);
      default:         return 32'(c.conversion_wait_time);
    endcase
  endfunction

  function automatic cfg_t short_timing(input int hi);
    cfg_t c;
    c.reset_low_time       = 10'($urandom_range(hi));
    c.presence_sample_time = 8'($urandom_range(hi));
    c.reset_recovery_time  = 10'($urandom_range(hi));
    c.slot_start_time      = 4'($urandom_range(hi));
    c.write_slot_time      = 7'($urandom_range(hi));
    c.read_sample_time     = 6'($urandom_range(hi));
    c.read_recovery_time   = 7'($urandom_range(hi));
    c.conversion_wait_time = 20'($urandom_range(4 * hi));
    return c;
  endfunction

  // APB write: setup cycle then access cycle, called at a falling edge
  task automatic write_register(input reg_idx_e idx, input logic [31:0] val);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic program_timing(input cfg_t c);
    for (int i = 0; i < 8; i++) write_register(reg_idx_e'(i), reg_value(c, reg_idx_e'(i)));
    timing = c;
  endtask

  // Offer one item, wait for its transfer, then maybe open a gap
  task automatic send(input mode_e m, input logic lvl, input bit typed = 1'b0,
                      input res_t want = '0);
    res_t r;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = m;
    s_axis_tdata  = {7'b0, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_status(m, lvl, r);
    status_due.push_back(typed ? want : r);
    @(negedge clk_i);
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
    end
  endtask

  // Stop offering and wait until every status word is back
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Feed ticks until the sequence ends; the bus answers at the sample points
  task automatic tick_until_idle(input logic [15:0] word, input logic absent, inout int count);
    logic lvl;
    while (rd_phase != PH_IDLE) begin
      case (rd_phase)
        PH_R1_WAIT: lvl = absent;
        PH_RL_SAMP: lvl = word[rd_bit];
        PH_RH_SAMP: lvl = word[{1'b1, rd_bit}];
        default:    lvl = 1'($urandom_range(1));
      endcase
      if ($urandom_range(31) == 0) send(MODE_START, 1'($urandom_range(1)));
      send(MODE_TICK, lvl);
      count++;
    end
  endtask

  task automatic run_phase(input cfg_t c, input int budget, input int absent_pct);
    int          n;
    logic        absent;
    logic [15:0] word;
    n = 0;
    program_timing(c);
    while (n < budget) begin
      repeat ($urandom_range(2)) send(MODE_TICK, 1'($urandom_range(1)));
      absent = ($urandom_range(99) < absent_pct);
      word = ($urandom_range(9) < 6) ? 16'($urandom) : TEMP_CORNERS[$urandom_range(5)];
      send(MODE_START, 1'($urandom_range(1)));
      n++;
      tick_until_idle(word, absent, n);
    end
    drain();
  endtask

  // Receiver: own stall pattern, plus a long periodic hold-off
  int rcv_cycle = 0;
  int hold_left = 0;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else if (rcv_cycle % 3000 == 700) begin
      m_axis_tready = 1'b0;
      hold_left = 120;
    end else begin
      case ((rcv_cycle / 1000) % 4)
        0:       m_axis_tready = 1'b1;
        1:       m_axis_tready = 1'($urandom_range(1));
        2:       m_axis_tready = ($urandom_range(7) != 0);
        default: m_axis_tready = (rcv_cycle % 8 < 5);
      endcase
    end
    rcv_cycle++;
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Status transfer check against the oldest prediction
  always @(posedge clk_i) begin
    res_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[27:0]);
      if (status_due.size() == 0) begin
        $error("status transfer with nothing expected: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = status_due.pop_front();
        check_field("drive_low", want.drive_low, got.drive_low);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("done_res", want.done_res, got.done_res);
        check_field("present", want.present, got.present);
        check_field("raw_temperature", want.raw_temperature, got.raw_temperature);
        check_field("whole_degrees", want.whole_degrees, got.whole_degrees);
      end
    end
  end

  // Main sequence
  initial begin
    cfg_t c;
    int   n;
    n = 0;
    timing = '{RST_RESET_LOW, RST_PRES_SAMPLE, RST_RESET_REC, RST_SLOT_START,
               RST_WRITE_SLOT, RST_READ_SAMPLE, RST_READ_REC, RST_CONV_WAIT};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed script, all timings at their lower end
    program_timing('0);
    foreach (script[i]) send(script[i].kind, script[i].level, script[i].typed, script[i].want);
    tick_until_idle(16'($urandom), 1'b0, n);
    drain();

    // random sequences under several timing setups
    run_phase('0, 300, 15);
    run_phase(short_timing(3), 350, 15);
    run_phase(short_timing(7), 350, 15);

    // slot and wait registers at their top value; nobody answers, so only the
    // presence wait runs long
    c = '{10'd0, 8'hFF, 10'd0, 4'hF, 7'h7F, 6'h3F, 7'h7F, 20'hFFFFF};
    run_phase(c, 1, 100);

    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("onewire_temperature_reader verification clean");
    end else begin
      $display("onewire_temperature_reader verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("onewire_temperature_reader verification failed");
    $finish;
  end

endmodule
